// ----- hdl/tmc_pkg.sv -----
// Shared types, constants and constant tables for the thrust to motor command block.
// No dependencies. Every other file in hdl imports this package.
package tmc_pkg;

	localparam int unsigned LG_W   = 21;
	localparam int unsigned LHS_W  = 24;
	localparam int unsigned RHS_W  = 38;
	localparam int unsigned CMP_W  = 40;
	localparam int unsigned LG_STEPS = 16;

	localparam logic signed [LHS_W-1:0] K2_Q16 = 24'sd746708;
	localparam logic [63:0] RHS_SCALE = 64'd172412;

	localparam logic REG_IDX_FLOOR = 1'b0;
	localparam logic REG_IDX_CEIL  = 1'b1;

	localparam logic LOG_SEL_RPM = 1'b0;
	localparam logic LOG_SEL_MV  = 1'b1;

	typedef logic [RHS_W-1:0] rhs_t;
	typedef rhs_t rhs_tab_t [256];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_A,
		ST_WAIT_A,
		ST_START_B,
		ST_WAIT_B,
		ST_BOUNDS,
		ST_SEARCH,
		ST_OUT
	} tmc_state_t;

	typedef struct packed {
		logic       load;
		logic       log_start;
		logic       log_sel;
		logic       save_a;
		logic       calc_lhs;
		logic       chk_bounds;
		logic       search_step;
		logic [2:0] bit_idx;
		logic       finish;
	} tmc_cmd_t;

	typedef struct packed {
		logic decided;
		logic log_done;
		logic out_free;
	} tmc_sts_t;

	// Base-two logarithm in unsigned Q16, evaluated at elaboration only.
	function automatic logic [LG_W-1:0] lg_const(input logic [31:0] v);
		logic [63:0] m;
		logic [4:0]  k;
		logic [15:0] frac;
		k = 5'd0;
		frac = 16'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) k = 5'(i);
		end
		m = {32'd0, v} << (5'd31 - k);
		for (int j = 0; j < 16; j++) begin
			m = (m * m) >> 31;
			frac = {frac[14:0], 1'b0};
			if (|m[63:32]) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return {k, frac};
	endfunction

	function automatic rhs_tab_t build_rhs_tab();
		rhs_tab_t t;
		for (int c = 0; c < 256; c++) begin
			t[c] = RHS_W'(RHS_SCALE * {43'd0, lg_const(32'(c))});
		end
		return t;
	endfunction

	localparam rhs_tab_t RHS_TAB = build_rhs_tab();

endpackage

// ----- hdl/tmc_log.sv -----
// Iterative base-two logarithm unit, one squaring per cycle, result in Q16.
// Depends on tmc_pkg.
module tmc_log
	import tmc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [31:0]     value,
	output logic            done,
	output logic [LG_W-1:0] result
);

	logic [31:0] m_q;
	logic [4:0]  k_q;
	logic [15:0] frac_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  top_bit;
	logic [63:0] prod;
	logic [32:0] sq;

	always_comb begin
		top_bit = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (value[i]) top_bit = 5'(i);
		end
	end

	assign prod = {32'd0, m_q} * {32'd0, m_q};
	assign sq   = prod[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(LG_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= top_bit;
			m_q    <= value << (5'd31 - top_bit);
			frac_q <= 16'd0;
		end else if (busy_q) begin
			frac_q <= {frac_q[14:0], sq[32]};
			m_q    <= sq[32] ? sq[32:1] : sq[31:0];
		end
	end

	assign done   = done_q;
	assign result = {k_q, frac_q};

endmodule

// ----- hdl/tmc_dp.sv -----
// Datapath: input capture, log-domain comparisons, bit-wise command search and result register.
// Depends on tmc_pkg and tmc_log.
module tmc_dp
	import tmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tmc_cmd_t    cmd,
	output tmc_sts_t    sts,
	input  logic [7:0]  cmd_floor,
	input  logic [7:0]  cmd_ceil,
	input  logic [31:0] in_rpm,
	input  logic [15:0] in_mv,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_cmd,
	output logic        out_clamped,
	output logic        out_grp,
	output logic        out_last
);

	logic [31:0]             rpm_q;
	logic [15:0]             mv_q;
	logic                    last_q;
	logic [LG_W-1:0]         lga_q;
	logic signed [LHS_W-1:0] lhs_q;
	logic [7:0]              cmd_q;
	logic                    clamped_q;
	logic                    decided_q;
	logic                    group_ok_q;
	logic                    out_valid_q;
	logic [7:0]              out_cmd_q;
	logic                    out_clamped_q;
	logic                    out_grp_q;
	logic                    out_last_q;

	logic                    log_done;
	logic [LG_W-1:0]         log_res;
	logic [31:0]             log_val;
	logic signed [LHS_W-1:0] lhs_next;
	logic signed [CMP_W-1:0] lhs_ext;
	logic signed [CMP_W-1:0] rhs_fl;
	logic signed [CMP_W-1:0] rhs_ce;
	logic signed [CMP_W-1:0] rhs_cand;
	logic [7:0]              cand;
	logic                    below;
	logic                    above;

	assign log_val = (cmd.log_sel == LOG_SEL_MV) ? {16'd0, mv_q} : rpm_q;

	tmc_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.value  (log_val),
		.done   (log_done),
		.result (log_res)
	);

	assign lhs_next = $signed({2'b00, lga_q, 1'b0})
		- ($signed({3'b000, log_res}) + $signed({2'b00, log_res, 1'b0}))
		+ K2_Q16;

	assign lhs_ext  = {lhs_q, 16'd0};
	assign rhs_fl   = $signed({2'b00, RHS_TAB[cmd_floor]});
	assign rhs_ce   = $signed({2'b00, RHS_TAB[cmd_ceil]});
	assign cand     = cmd_q | (8'd1 << cmd.bit_idx);
	assign rhs_cand = $signed({2'b00, RHS_TAB[cand]});
	assign below    = (cmd_floor != 8'd0) && (lhs_ext <= rhs_fl);
	assign above    = (cmd_ceil == 8'd0) || (lhs_ext > rhs_ce);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rpm_q     <= in_rpm;
			mv_q      <= in_mv;
			last_q    <= in_last;
			decided_q <= (in_mv == 16'd0) || (in_rpm == 32'd0);
			clamped_q <= (in_mv == 16'd0) || (in_rpm == 32'd0);
			cmd_q     <= (in_mv == 16'd0) ? cmd_ceil : cmd_floor;
		end else if (cmd.chk_bounds) begin
			if (below) begin
				decided_q <= 1'b1;
				clamped_q <= 1'b1;
				cmd_q     <= cmd_floor;
			end else if (above) begin
				decided_q <= 1'b1;
				clamped_q <= 1'b1;
				cmd_q     <= cmd_ceil;
			end else begin
				clamped_q <= 1'b0;
				cmd_q     <= 8'd0;
			end
		end else if (cmd.search_step) begin
			if ((cand <= cmd_ceil) && (lhs_ext >= rhs_cand)) cmd_q <= cand;
		end
		if (cmd.save_a) lga_q <= log_res;
		if (cmd.calc_lhs) lhs_q <= lhs_next;
		if (cmd.finish) begin
			out_cmd_q     <= cmd_q;
			out_clamped_q <= clamped_q;
			out_grp_q     <= last_q & group_ok_q & ~clamped_q;
			out_last_q    <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			group_ok_q  <= 1'b1;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				group_ok_q  <= last_q | (group_ok_q & ~clamped_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.decided  = decided_q;
	assign sts.log_done = log_done;
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid   = out_valid_q;
	assign out_cmd     = out_cmd_q;
	assign out_clamped = out_clamped_q;
	assign out_grp     = out_grp_q;
	assign out_last    = out_last_q;

endmodule

// ----- hdl/tmc_ctrl.sv -----
// Controller state machine that sequences the logarithms, bound checks and command search.
// Depends on tmc_pkg.
module tmc_ctrl
	import tmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tmc_sts_t sts,
	output tmc_cmd_t cmd
);

	tmc_state_t state_q;
	tmc_state_t state_d;
	logic [2:0] bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= 3'd7;
		end else begin
			state_q <= state_d;
			if (cmd.chk_bounds) bit_q <= 3'd7;
			else if (cmd.search_step) bit_q <= bit_q - 3'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START_A;
			end
			ST_START_A: begin
				state_d = sts.decided ? ST_OUT : ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (sts.log_done) state_d = ST_START_B;
			end
			ST_START_B: begin
				state_d = ST_WAIT_B;
			end
			ST_WAIT_B: begin
				if (sts.log_done) state_d = ST_BOUNDS;
			end
			ST_BOUNDS: begin
				state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sts.decided || (bit_q == 3'd0)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.bit_idx = bit_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_START_A: begin
				cmd.log_start = ~sts.decided;
				cmd.log_sel   = LOG_SEL_RPM;
			end
			ST_WAIT_A: begin
				cmd.save_a = sts.log_done;
			end
			ST_START_B: begin
				cmd.log_start = 1'b1;
				cmd.log_sel   = LOG_SEL_MV;
			end
			ST_WAIT_B: begin
				cmd.log_sel  = LOG_SEL_MV;
				cmd.calc_lhs = sts.log_done;
			end
			ST_BOUNDS: begin
				cmd.chk_bounds = 1'b1;
			end
			ST_SEARCH: begin
				cmd.search_step = ~sts.decided;
			end
			ST_OUT: begin
				cmd.finish = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/thrust_to_motor_command_top.sv -----
// Top level: configuration registers, stream ports, controller and datapath.
// Depends on tmc_pkg, tmc_ctrl and tmc_dp.
//
// One motor transfer at a time is worked on. An item whose supply voltage or speed is zero
// skips both logarithms on its way from acceptance to the output state. Any other item
// takes two passes of the single shared logarithm unit (each a start, sixteen squaring
// multiplies and a completion), then a bound check, an eight-step command search that is cut
// short when the item is clamped at the bound check, and an output state. The input is ready
// again in the cycle after a result is loaded, and a stalled output holds the controller until
// the result register is free.
// A finished result waits in the output register while the next transfer is accepted.
module thrust_to_motor_command_top
	import tmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // speed_squared [31:0], supply_millivolts [47:32]
	input  logic        s_axis_tlast,  // last_motor
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // motor_command [7:0]
	output logic [1:0]  m_axis_tuser,  // was_clamped [0], group_in_range [1]
	output logic        m_axis_tlast   // group_end
);

	logic [7:0] floor_q;
	logic [7:0] ceil_q;
	tmc_cmd_t   cmd;
	tmc_sts_t   sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 8'd0;
			ceil_q  <= 8'd255;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_IDX_FLOOR: floor_q <= pwdata[7:0];
				REG_IDX_CEIL:  ceil_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_FLOOR: prdata = {24'd0, floor_q};
			REG_IDX_CEIL:  prdata = {24'd0, ceil_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	tmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cmd_floor   (floor_q),
		.cmd_ceil    (ceil_q),
		.in_rpm      (s_axis_tdata[31:0]),
		.in_mv       (s_axis_tdata[47:32]),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_cmd     (m_axis_tdata),
		.out_clamped (m_axis_tuser[0]),
		.out_grp     (m_axis_tuser[1]),
		.out_last    (m_axis_tlast)
	);

endmodule
